/* src/tsnb_pkg.sv */
// Package for the texture sampler: sizes, opcodes, register indexes and the
// request/response structs shared by the sampler's modules.
// Depends on nothing.
`default_nettype none

package tsnb_pkg;

  // Texture geometry.
  localparam int MaxDim     = 256;
  localparam int AxisBits   = $clog2(MaxDim);
  localparam int DimBits    = AxisBits + 1;
  localparam int AddrBits   = 2 * AxisBits;
  localparam int StoreDepth = MaxDim * MaxDim;

  // Coordinates and products.
  localparam int CoordBits  = 24;
  localparam int FracBits   = 16;
  localparam int WeightBits = 8;
  localparam int ProdBits   = CoordBits + DimBits;
  localparam int QuotBits   = ProdBits - 1 - FracBits;
  localparam int CntBits    = $clog2(QuotBits + 1);
  localparam int UnitBits   = FracBits + 1;
  localparam int FxBits     = UnitBits + AxisBits;
  localparam int WtBits     = 2 * WeightBits + 1;

  // Texels and blending.
  localparam int TexelBits  = 32;
  localparam int ChanBits   = 8;
  localparam int NumChan    = 3;
  localparam int AccBits    = ChanBits + 2 * WeightBits;
  localparam int NumTaps    = 4;
  localparam int TapBits    = $clog2(NumTaps);
  localparam logic [ChanBits-1:0] AlphaOpaque = '1;

  // Stream payload widths.
  localparam int InDataBits  = 96;
  localparam int InUserBits  = 2;
  localparam int OutDataBits = TexelBits;
  localparam int CfgIdxBits  = 1;

  typedef enum logic [InUserBits-1:0] {
    OpWrite    = 2'd0,
    OpNearest  = 2'd1,
    OpBilinear = 2'd2
  } tsnb_op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } tsnb_reg_e;

  typedef struct packed {
    logic                start;
    logic [QuotBits-1:0] dividend;
    logic [DimBits-1:0]  divisor;
  } tsnb_div_req_t;

  typedef struct packed {
    logic                done;
    logic [AxisBits-1:0] rem;
  } tsnb_div_rsp_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [AddrBits-1:0]  addr;
    logic [TexelBits-1:0] wdata;
  } tsnb_mem_req_t;

endpackage

`default_nettype wire

/* src/texture_sampler_nearest_bilinear.sv */
// Top level of the texture sampler: stream ports, size registers, sequencer
// and sampling datapath. Depends on tsnb_pkg, tsnb_mod and tsnb_store.
//
// Channel    Direction  Handshake                    Payload
// s_axis     in         s_axis_tvalid/s_axis_tready  tdata: index, texel, u, v; tuser: op
// m_axis     out        m_axis_tvalid/m_axis_tready  tdata: sampled color
// cfg        in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// A texel write is taken while idle and the block is ready again right after it.
// A nearest sample waits on the two 16-step remainder units that wrap u and v.
// A bilinear sample makes its four tap reads, one after another, through the
// single store port.
// Reset clears the control state and sets both sizes to 8; the store holds
// whatever it held, so only texels written since power-up may be sampled.
// A new word is taken while a finished result still waits in the output
// register; a sample that finishes before that result leaves waits for it.
`default_nettype none

module texture_sampler_nearest_bilinear (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Fields from bit 0 up: texel_index[15:0], texel_value[47:16],
  // u_coord[71:48], v_coord[95:72].
  input  wire logic [tsnb_pkg::InDataBits-1:0]  s_axis_tdata,
  // Fields from bit 0 up: opcode[1:0].
  input  wire logic [tsnb_pkg::InUserBits-1:0]  s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: sampled_color[31:0].
  output logic [tsnb_pkg::OutDataBits-1:0]      m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tsnb_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [tsnb_pkg::DimBits-1:0]     cfg_data_i
);
  import tsnb_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StMul, StDivGo, StDivWait, StRow, StNearRd,
    StSplit, StWeight, StBilRd, StBilLast, StOut
  } state_e;

  localparam logic signed [CoordBits-1:0] CoordOne = CoordBits'(1 << FracBits);
  localparam logic [TapBits-1:0]          TapLast  = TapBits'(NumTaps - 1);
  localparam logic [DimBits-1:0]          DimReset = DimBits'(8);

  // Clamp to [0, 1] in fixed point.
  function automatic logic [UnitBits-1:0] clamp_unit(input logic signed [CoordBits-1:0] c);
    logic [UnitBits-1:0] r;
    if (c[CoordBits-1]) r = '0;
    else if (c > CoordOne) r = UnitBits'(CoordOne);
    else r = c[UnitBits-1:0];
    return r;
  endfunction

  // Clamp a size write to [1, MaxDim].
  function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] d);
    logic [DimBits-1:0] r;
    if (d == '0) r = DimBits'(1);
    else if (d > DimBits'(MaxDim)) r = DimBits'(MaxDim);
    else r = d;
    return r;
  endfunction

  // A negative coordinate with a nonzero remainder wraps to size minus remainder.
  function automatic logic [AxisBits-1:0] fix_wrap(input logic neg,
                                                   input logic [AxisBits-1:0] rem,
                                                   input logic [DimBits-1:0] size);
    logic [AxisBits-1:0] r;
    if (neg && rem != '0) r = AxisBits'(size - {1'b0, rem});
    else r = rem;
    return r;
  endfunction

  // Input payload.
  tsnb_op_e                     in_op;
  logic                         in_fire;
  logic [AddrBits-1:0]          in_index;
  logic [TexelBits-1:0]         in_texel;
  logic signed [CoordBits-1:0]  in_u, in_v;

  assign in_op    = tsnb_op_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[AddrBits-1:0];
  assign in_texel = s_axis_tdata[AddrBits +: TexelBits];
  assign in_u     = s_axis_tdata[AddrBits + TexelBits +: CoordBits];
  assign in_v     = s_axis_tdata[AddrBits + TexelBits + CoordBits +: CoordBits];

  // Control state.
  state_e               state_q, state_d;
  logic [DimBits-1:0]   w_q, h_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 acc_vld_q;
  logic [TapBits-1:0]   acc_tap_q;

  // Sample datapath.
  logic                        is_bil_q;
  logic signed [CoordBits-1:0] u_q, v_q;
  logic signed [ProdBits-1:0]  px_q, py_q;
  logic [FxBits-1:0]           fx_q, fy_q;
  logic [AxisBits-1:0]         x_q, x1_q, y_q, y1_q;
  logic [WeightBits-1:0]       tx_q, ty_q;
  logic [WtBits-1:0]           wt_q [NumTaps];
  logic [AddrBits-1:0]         row0_q, row1_q;
  logic [TapBits-1:0]          tap_q;
  logic [AccBits-1:0]          acc_q [NumChan];
  logic [OutDataBits-1:0]      out_data_q;

  logic [AxisBits-1:0]         wm1, hm1;
  logic [AxisBits-1:0]         x0_raw, y0_raw, x0_c, y0_c;
  logic [DimBits-1:0]          inv_tx, inv_ty;
  logic signed [ProdBits-1:0]  u_ext, v_ext, w_ext, h_ext;
  logic [ProdBits-1:0]         mag_x, mag_y;

  tsnb_div_req_t  req_x, req_y;
  tsnb_div_rsp_t  rsp_x, rsp_y;
  tsnb_mem_req_t  mem_req;
  logic [TexelBits-1:0] rdata;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_op == OpNearest || in_op == OpBilinear)) state_d = StMul;
      end
      StMul:     state_d = is_bil_q ? StSplit : StDivGo;
      StDivGo:   state_d = StDivWait;
      StDivWait: if (rsp_x.done) state_d = StRow;
      StRow:     state_d = StNearRd;
      StNearRd:  state_d = StOut;
      StSplit:   state_d = StWeight;
      StWeight:  state_d = StBilRd;
      StBilRd:   if (tap_q == TapLast) state_d = StBilLast;
      StBilLast: state_d = StOut;
      StOut:     if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      w_q         <= DimReset;
      h_q         <= DimReset;
      out_valid_q <= 1'b0;
      acc_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_vld_q <= (state_q == StBilRd);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (tsnb_reg_e'(cfg_index_i))
          RegWidth:  w_q <= clamp_dim(cfg_data_i);
          RegHeight: h_q <= clamp_dim(cfg_data_i);
        endcase
      end
      if (state_q == StOut && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Operands for the products and the wrap.
  assign u_ext = ProdBits'(u_q);
  assign v_ext = ProdBits'(v_q);
  assign w_ext = $signed(ProdBits'(w_q));
  assign h_ext = $signed(ProdBits'(h_q));
  assign wm1   = AxisBits'(w_q - 1'b1);
  assign hm1   = AxisBits'(h_q - 1'b1);
  assign mag_x = px_q[ProdBits-1] ? ProdBits'(-px_q) : ProdBits'(px_q);
  assign mag_y = py_q[ProdBits-1] ? ProdBits'(-py_q) : ProdBits'(py_q);

  // Bilinear tap columns and rows; the second tap stops at the last texel.
  assign x0_raw = fx_q[FracBits +: AxisBits];
  assign y0_raw = fy_q[FracBits +: AxisBits];
  assign x0_c   = (x0_raw > wm1) ? wm1 : x0_raw;
  assign y0_c   = (y0_raw > hm1) ? hm1 : y0_raw;
  assign inv_tx = DimBits'(1 << WeightBits) - DimBits'(tx_q);
  assign inv_ty = DimBits'(1 << WeightBits) - DimBits'(ty_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_bil_q <= (in_op == OpBilinear);
      u_q      <= in_u;
      v_q      <= in_v;
    end
    if (state_q == StMul) begin
      px_q <= u_ext * w_ext;
      py_q <= v_ext * h_ext;
      fx_q <= FxBits'(clamp_unit(u_q)) * FxBits'(wm1);
      fy_q <= FxBits'(clamp_unit(v_q)) * FxBits'(hm1);
    end
    if (state_q == StDivWait && rsp_x.done) begin
      x_q <= fix_wrap(px_q[ProdBits-1], rsp_x.rem, w_q);
      y_q <= fix_wrap(py_q[ProdBits-1], rsp_y.rem, h_q);
    end
    if (state_q == StRow) begin
      row0_q <= AddrBits'(y_q * w_q);
    end
    if (state_q == StSplit) begin
      x_q  <= x0_c;
      y_q  <= y0_c;
      x1_q <= (x0_c < wm1) ? AxisBits'(x0_c + 1'b1) : wm1;
      y1_q <= (y0_c < hm1) ? AxisBits'(y0_c + 1'b1) : hm1;
      tx_q <= fx_q[FracBits-1 -: WeightBits];
      ty_q <= fy_q[FracBits-1 -: WeightBits];
    end
    if (state_q == StWeight) begin
      wt_q[0] <= WtBits'(inv_tx * inv_ty);
      wt_q[1] <= WtBits'({1'b0, tx_q} * inv_ty);
      wt_q[2] <= WtBits'(inv_tx * {1'b0, ty_q});
      wt_q[3] <= WtBits'({1'b0, tx_q} * {1'b0, ty_q});
      row0_q  <= AddrBits'(y_q * w_q);
      row1_q  <= AddrBits'(y1_q * w_q);
      tap_q   <= '0;
    end
    if (state_q == StBilRd) begin
      tap_q <= tap_q + 1'b1;
    end
    acc_tap_q <= tap_q;
    if (state_q == StOut && out_free) begin
      out_data_q <= is_bil_q
                    ? {AlphaOpaque, acc_q[2][AccBits-1 -: ChanBits],
                       acc_q[1][AccBits-1 -: ChanBits], acc_q[0][AccBits-1 -: ChanBits]}
                    : rdata;
    end
  end

  // Per-channel blend: one tap's weighted channels are added each cycle as
  // the tap's read data returns. Channel 0 is blue, 2 is red.
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    always_ff @(posedge clk_i) begin
      if (state_q == StWeight) begin
        acc_q[c] <= '0;
      end else if (acc_vld_q) begin
        acc_q[c] <= acc_q[c] + AccBits'(rdata[c*ChanBits +: ChanBits] * wt_q[acc_tap_q]);
      end
    end
  end

  // Remainder units for the nearest wrap of x and y.
  assign req_x.start    = (state_q == StDivGo);
  assign req_x.dividend = mag_x[ProdBits-2 -: QuotBits];
  assign req_x.divisor  = w_q;
  assign req_y.start    = (state_q == StDivGo);
  assign req_y.dividend = mag_y[ProdBits-2 -: QuotBits];
  assign req_y.divisor  = h_q;

  tsnb_mod u_mod_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_x),
    .rsp_o  (rsp_x)
  );

  tsnb_mod u_mod_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_y),
    .rsp_o  (rsp_y)
  );

  // Store port: writes straight from the input, reads from the sequencer.
  // Every 16-bit index lies inside the store.
  always_comb begin
    mem_req.we    = in_fire && (in_op == OpWrite);
    mem_req.re    = 1'b0;
    mem_req.wdata = in_texel;
    mem_req.addr  = in_index;
    if (state_q == StNearRd) begin
      mem_req.re   = 1'b1;
      mem_req.addr = AddrBits'(row0_q + x_q);
    end else if (state_q == StBilRd) begin
      mem_req.re   = 1'b1;
      mem_req.addr = AddrBits'((tap_q[1] ? row1_q : row0_q) + (tap_q[0] ? x1_q : x_q));
    end
  end

  tsnb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* src/tsnb_mod.sv */
// Iterative remainder unit: dividend modulo divisor, one quotient bit a cycle.
// Depends on tsnb_pkg.
`default_nettype none

module tsnb_mod (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tsnb_pkg::tsnb_div_req_t req_i,
  output tsnb_pkg::tsnb_div_rsp_t     rsp_o
);
  import tsnb_pkg::*;

  logic [CntBits-1:0]  cnt_q;
  logic [QuotBits-1:0] sh_q;
  logic [DimBits-1:0]  div_q;
  logic [AxisBits-1:0] rem_q;
  logic                done_q;
  logic [DimBits-1:0]  trial;

  // Bring down the next dividend bit beside the partial remainder.
  assign trial = {rem_q, sh_q[QuotBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= CntBits'(QuotBits);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntBits'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q  <= {sh_q[QuotBits-2:0], 1'b0};
      rem_q <= (trial >= div_q) ? AxisBits'(trial - div_q) : AxisBits'(trial);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* src/tsnb_store.sv */
// Texel store: single-port synchronous memory, one read or write a cycle,
// registered read data. Depends on tsnb_pkg.
`default_nettype none

module tsnb_store (
  input  wire logic                    clk_i,
  input  wire tsnb_pkg::tsnb_mem_req_t req_i,
  output logic [tsnb_pkg::TexelBits-1:0] rdata_o
);
  import tsnb_pkg::*;

  logic [TexelBits-1:0] mem [StoreDepth];
  logic [TexelBits-1:0] rdata_q;

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/tsnb_checker.sv */
// Port-level checks for the texture sampler, bound to its top level.
// Depends on tsnb_pkg and texture_sampler_nearest_bilinear.
`default_nettype none

module tsnb_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic [tsnb_pkg::InUserBits-1:0]  s_axis_tuser,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [tsnb_pkg::OutDataBits-1:0] m_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o
);
  import tsnb_pkg::*;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // A result that is not taken stays and holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result can appear the cycle after a word is taken into an empty block.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // A texel write finishes at once.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == OpWrite |=> s_axis_tready)
    else $error("not ready after a write");

  // A sample closes the input once it is taken.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (s_axis_tuser == OpNearest || s_axis_tuser == OpBilinear)
    |=> !s_axis_tready)
    else $error("input open during a sample");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind texture_sampler_nearest_bilinear tsnb_checker u_tsnb_checker (.*);

`default_nettype wire
